### hdl/ssag_pkg.sv
// ----------------------------------------------------------------------------
// ssag_pkg
// Shared types and constants for the strided scatter address generator.
// ----------------------------------------------------------------------------
`default_nettype none
package ssag_pkg;
  localparam int REG_COUNT = 8;
  localparam int REG_W     = 64;
  localparam int IDX_W     = 4;
  localparam int AX_W      = 3;
  localparam int LANE_W    = 16;
  localparam int WORD_W    = 32;

  localparam logic [REG_W-1:0] EXT_RESET   = 64'h0001_0001_0001_0001;
  localparam logic [REG_W-1:0] BEGIN_RESET = 64'h0;

  // register pair index
  localparam logic [1:0] PAIR_SLICE = 2'd0;
  localparam logic [1:0] PAIR_FULL  = 2'd1;
  localparam logic [1:0] PAIR_STEP  = 2'd2;
  localparam logic [1:0] PAIR_START = 2'd3;

  // per-axis phases
  localparam logic [1:0] PH_STRIDE = 2'd0;
  localparam logic [1:0] PH_SCALE  = 2'd1;
  localparam logic [1:0] PH_ACCUM  = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } ssag_cmd_t;

  typedef struct packed {
    logic last_step;
  } ssag_sts_t;
endpackage
`default_nettype wire

### hdl/ssag_datapath.sv
// ----------------------------------------------------------------------------
// ssag_datapath
// Config registers, odometer and shared-multiplier address accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
module ssag_datapath import ssag_pkg::*; #(
  parameter int NUM_AXES  = 8,
  parameter int DIM_BITS  = 16,
  parameter int ADDR_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [REG_W-1:0]  cfg_data,
  input  wire logic [WORD_W-1:0] in_element,
  input  wire ssag_cmd_t         cmd,
  output ssag_sts_t              sts,
  output logic [WORD_W-1:0]      out_dest_address,
  output logic [WORD_W-1:0]      out_element_out,
  output logic                   out_last
);
  localparam logic [WORD_W-1:0] AMASK = (ADDR_BITS >= WORD_W) ? {WORD_W{1'b1}} :
                                        WORD_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [AX_W-1:0] AX_TOP = AX_W'(NUM_AXES - 1);

  logic [REG_W-1:0]    regs_r [REG_COUNT];
  logic [DIM_BITS-1:0] coord_r [REG_COUNT];
  logic [WORD_W-1:0]   elem_r, acc_r, scale_r, mreg_r;
  logic [WORD_W-1:0]   out_addr_r, out_elem_r;
  logic                out_last_r;
  logic [AX_W-1:0]     axis_r;
  logic [1:0]          phase_r;
  logic                carry_r, allmax_r;

  logic [DIM_BITS-1:0] ext_slice, ext_full, ext_step, ext_start, c, cmax;
  logic [WORD_W-1:0]   mul_a, mul_b, mul_p;
  logic                at_max;

  function automatic logic [DIM_BITS-1:0] lane_of(input logic [REG_W-1:0] r,
                                                  input logic [1:0] q);
    logic [LANE_W-1:0] l;
    l = r[LANE_W*q +: LANE_W];
    return l[DIM_BITS-1:0];
  endfunction

  assign ext_slice = lane_of(regs_r[{PAIR_SLICE, axis_r[2]}], axis_r[1:0]);
  assign ext_full  = lane_of(regs_r[{PAIR_FULL,  axis_r[2]}], axis_r[1:0]);
  assign ext_step  = lane_of(regs_r[{PAIR_STEP,  axis_r[2]}], axis_r[1:0]);
  assign ext_start = lane_of(regs_r[{PAIR_START, axis_r[2]}], axis_r[1:0]);
  assign c         = coord_r[axis_r];
  assign cmax      = (ext_slice == '0) ? '0 : ext_slice - 1'b1;
  assign at_max    = (c >= cmax);

  always_comb begin
    case (phase_r)
      PH_STRIDE: begin
        mul_a = WORD_W'(c);
        mul_b = WORD_W'(signed'(ext_step));
      end
      PH_SCALE: begin
        mul_a = mreg_r + WORD_W'(ext_start);
        mul_b = scale_r;
      end
      default: begin
        mul_a = scale_r;
        mul_b = WORD_W'(ext_full);
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign sts.last_step = (axis_r == '0) && (phase_r == PH_ACCUM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_r[i]  <= (i >= 6) ? BEGIN_RESET : EXT_RESET;
        coord_r[i] <= '0;
      end
      axis_r  <= AX_TOP;
      phase_r <= PH_STRIDE;
      carry_r <= 1'b1;
      allmax_r <= 1'b1;
    end else begin
      if (cfg_we && cfg_index < IDX_W'(REG_COUNT))
        regs_r[cfg_index[AX_W-1:0]] <= cfg_data;
      if (cmd.load) begin
        elem_r   <= in_element;
        acc_r    <= '0;
        scale_r  <= WORD_W'(1);
        axis_r   <= AX_TOP;
        phase_r  <= PH_STRIDE;
        carry_r  <= 1'b1;
        allmax_r <= 1'b1;
      end else if (cmd.step) begin
        case (phase_r)
          PH_STRIDE: begin
            mreg_r  <= mul_p;
            phase_r <= PH_SCALE;
            if (!at_max) allmax_r <= 1'b0;
            if (carry_r) begin
              if (at_max) begin
                coord_r[axis_r] <= '0;
              end else begin
                coord_r[axis_r] <= c + 1'b1;
                carry_r <= 1'b0;
              end
            end
          end
          PH_SCALE: begin
            mreg_r  <= mul_p;
            phase_r <= PH_ACCUM;
          end
          default: begin
            acc_r   <= acc_r + mreg_r;
            scale_r <= mul_p;
            phase_r <= PH_STRIDE;
            axis_r  <= axis_r - 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_addr_r <= acc_r & AMASK;
      out_elem_r <= elem_r;
      out_last_r <= allmax_r;
    end
  end

  assign out_dest_address = out_addr_r;
  assign out_element_out  = out_elem_r;
  assign out_last         = out_last_r;
endmodule
`default_nettype wire

### hdl/ssag_ctrl.sv
// ----------------------------------------------------------------------------
// ssag_ctrl
// Sequencer: accepts a request, steps the datapath, hands off the result.
// ----------------------------------------------------------------------------
`default_nettype none
module ssag_ctrl import ssag_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  input  wire ssag_sts_t sts,
  output ssag_cmd_t cmd
);
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   can_pub;

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign can_pub       = !out_valid_r || !out_stall;
  assign cmd.load      = (state_r == S_IDLE) && in_valid;
  assign cmd.step      = (state_r == S_RUN);
  assign cmd.publish   = (state_r == S_FIN) && can_pub;
  assign out_valid_nxt = cmd.publish || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_RUN;
        S_RUN:  if (sts.last_step) state_r <= S_FIN;
        S_FIN: begin
          if (can_pub) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_load_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_RUN) else $error("load did not start run");
  a_pub_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid_r) else $error("publish lost");
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !(out_valid_r && out_stall)) else $error("result overwritten");
`endif
endmodule
`default_nettype wire

### hdl/strided_scatter_address_gen.sv
// ----------------------------------------------------------------------------
// strided_scatter_address_gen
// Scatter address generator for strided-slice gradients.
// ----------------------------------------------------------------------------
// A request is taken only while the block is idle. It walks the axes from the
// top axis down to axis 0 before its result is registered; the next request
// is accepted only once that result is handed off, so requests never overlap.
// One shared 32-bit multiplier is used three times per axis (coordinate times
// stride, term times scale, scale times full extent). A finished address waits
// while the previous result is still stalled. Configuration is written through
// cfg_valid/cfg_ready by the user while idle; the block does not enforce it.
`default_nettype none
module strided_scatter_address_gen import ssag_pkg::*; #(
  parameter int NUM_AXES  = 8,
  parameter int DIM_BITS  = 16,
  parameter int ADDR_BITS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [REG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [WORD_W-1:0] in_element,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [WORD_W-1:0]      out_dest_address,
  output logic [WORD_W-1:0]      out_element_out,
  output logic                   out_last
);
  ssag_cmd_t cmd;
  ssag_sts_t sts;

  assign cfg_ready = 1'b1;

  ssag_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  ssag_datapath #(
    .NUM_AXES(NUM_AXES), .DIM_BITS(DIM_BITS), .ADDR_BITS(ADDR_BITS)
  ) u_dp (
    .clk, .rst_n,
    .cfg_we(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .in_element, .cmd, .sts,
    .out_dest_address, .out_element_out, .out_last
  );
endmodule
`default_nettype wire
